// ===== rtl/prpi_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the push-style rank iteration block.
// No dependencies; every other file imports this package.
package prpi_pkg;

    localparam int VTX_W      = 10;
    localparam int NCNT_W     = 11;
    localparam int EDGE_W     = 13;
    localparam int EADDR_W    = 12;
    localparam int RANK_W     = 32;
    localparam int RANK_FRAC  = 31;
    localparam int DAMP_W     = 16;
    localparam int ROUND_W    = 8;
    localparam int DEG_W      = 13;
    localparam int MAX_VERTICES = 1024;
    localparam int MAX_EDGES  = 4096;

    localparam logic [32:0]      RANK_ONE = 33'h0_8000_0000;
    localparam logic [DEG_W-1:0] DEG_MAX  = 13'h1FFF;

    localparam int DIV_N_W   = 48;
    localparam int DIV_D_W   = 27;
    localparam int DIV_CNT_W = 6;

    localparam logic [1:0] FUNC_LOAD    = 2'd0;
    localparam logic [1:0] FUNC_COMPUTE = 2'd1;
    localparam logic [1:0] FUNC_READ    = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_RANGE = 2'd2;

    localparam logic [1:0] DIV_INIT = 2'd0;
    localparam logic [1:0] DIV_TELE = 2'd1;
    localparam logic [1:0] DIV_PUSH = 2'd2;

    localparam logic [1:0] CFG_VERTEX_COUNT = 2'd0;
    localparam logic [1:0] CFG_ROUND_COUNT  = 2'd1;
    localparam logic [1:0] CFG_DAMPING      = 2'd2;

    typedef struct packed {
        logic [1:0]       func;
        logic [VTX_W-1:0] edge_source;
        logic [VTX_W-1:0] edge_target;
        logic [VTX_W-1:0] query_vertex;
    } t_in_item;

    typedef struct packed {
        logic [RANK_W-1:0] rank_value;
        logic [1:0]        status;
        logic [EDGE_W-1:0] edges_held;
    } t_out_item;

    typedef struct packed {
        logic              take;
        logic              res_init;
        logic [1:0]        res_status;
        logic              res_rank_cap;
        logic              edge_wr;
        logic              deg_inc;
        logic              q_rd;
        logic              div_start;
        logic [1:0]        div_sel;
        logic              init_wr;
        logic              clr_wr;
        logic              e_rd;
        logic              e_rd2;
        logic              push_wr;
        logic              u_rd;
        logic              u_mul;
        logic              u_wr;
        logic [NCNT_W-1:0] vtx;
        logic [EDGE_W-1:0] edge_idx;
    } t_cmd;

    typedef struct packed {
        logic [1:0]        func;
        logic              edge_bad;
        logic              store_full;
        logic              q_bad;
        logic              edge_skip;
        logic              div_done;
        logic [EDGE_W-1:0] edge_total;
    } t_sts;

endpackage

// ===== rtl/prpi_div.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
// Depends on prpi_pkg for widths.
module prpi_div
    import prpi_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [DIV_N_W-1:0] i_dividend,
    input  logic [DIV_D_W-1:0] i_divisor,
    output logic               o_done,
    output logic [DIV_N_W-1:0] o_quotient
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_D_W-1:0]   r_rem;
    logic [DIV_D_W-1:0]   r_div;
    logic [DIV_N_W-1:0]   r_quo;

    logic [DIV_D_W:0] w_rem_sh;
    logic [DIV_D_W:0] w_diff;
    logic             w_ge;

    assign w_rem_sh = {r_rem, r_quo[DIV_N_W-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_div});
    assign w_diff   = w_rem_sh - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_N_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_div <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DIV_D_W-1:0] : w_rem_sh[DIV_D_W-1:0];
            r_quo <= {r_quo[DIV_N_W-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== rtl/prpi_dp.sv =====
`timescale 1ns / 1ps
// Datapath: edge store, degree and rank memories, divider, damping math.
// Depends on prpi_pkg and prpi_div; driven by prpi_ctrl commands.
module prpi_dp
    import prpi_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  t_in_item          i_item,
    input  logic [NCNT_W-1:0] i_n,
    input  logic [DAMP_W-1:0] i_damping,
    output t_sts              o_sts,
    output logic [RANK_W-1:0] o_res_rank,
    output logic [1:0]        o_res_status
);

    logic [VTX_W-1:0]  src_mem [MAX_EDGES];
    logic [VTX_W-1:0]  dst_mem [MAX_EDGES];
    logic [DEG_W-1:0]  deg_mem [MAX_VERTICES];
    logic [RANK_W-1:0] cur_mem [MAX_VERTICES];
    logic [RANK_W-1:0] nxt_mem [MAX_VERTICES];

    t_in_item          r_item;
    logic [EDGE_W-1:0] r_total;
    logic [VTX_W-1:0]  r_src_rd;
    logic [VTX_W-1:0]  r_dst_rd;
    logic [DEG_W-1:0]  r_deg_rd;
    logic [RANK_W-1:0] r_cur_rd;
    logic [RANK_W-1:0] r_nxt_rd;
    logic [RANK_W-1:0] r_init;
    logic [RANK_W-1:0] r_tele;
    logic [1:0]        r_div_sel;
    logic [47:0]       r_prod;
    logic [RANK_W-1:0] r_res_rank;
    logic [1:0]        r_res_status;

    logic [VTX_W-1:0]   w_vaddr;
    logic [VTX_W-1:0]   w_deg_raddr;
    logic               w_deg_re;
    logic               w_deg_we;
    logic [DEG_W-1:0]   w_deg_wdata;
    logic [VTX_W-1:0]   w_cur_raddr;
    logic               w_cur_re;
    logic               w_cur_we;
    logic [RANK_W-1:0]  w_cur_wdata;
    logic [VTX_W-1:0]   w_nxt_raddr;
    logic               w_nxt_re;
    logic [VTX_W-1:0]   w_nxt_waddr;
    logic               w_nxt_we;
    logic [RANK_W-1:0]  w_nxt_wdata;
    logic [DIV_N_W-1:0] w_dividend;
    logic [DIV_D_W-1:0] w_divisor;
    logic               w_div_done;
    logic [DIV_N_W-1:0] w_quo;
    logic [16:0]        w_damp_c;
    logic [32:0]        w_push_sum;
    logic [48:0]        w_rnd;
    logic [32:0]        w_damped;
    logic [33:0]        w_upd;
    logic [RANK_W-1:0]  w_upd_sat;

    assign w_vaddr = i_cmd.vtx[VTX_W-1:0];

    // degree memory
    assign w_deg_re    = i_cmd.edge_wr | i_cmd.e_rd2;
    assign w_deg_raddr = i_cmd.edge_wr ? r_item.edge_source : r_src_rd;
    assign w_deg_we    = i_cmd.deg_inc | i_cmd.clr_wr;
    always_comb begin
        if (i_cmd.clr_wr) begin
            w_deg_wdata = '0;
        end else begin
            w_deg_wdata = (r_deg_rd == DEG_MAX) ? r_deg_rd : r_deg_rd + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_deg_we) begin
            deg_mem[i_cmd.clr_wr ? w_vaddr : r_item.edge_source] <= w_deg_wdata;
        end
        if (w_deg_re) begin
            r_deg_rd <= deg_mem[w_deg_raddr];
        end
    end

    // current rank memory
    assign w_cur_re    = i_cmd.q_rd | i_cmd.e_rd2;
    assign w_cur_raddr = i_cmd.q_rd ? r_item.query_vertex : r_src_rd;
    assign w_cur_we    = i_cmd.init_wr | i_cmd.u_wr | i_cmd.clr_wr;
    always_comb begin
        if (i_cmd.init_wr) begin
            w_cur_wdata = (i_cmd.vtx < i_n) ? r_init : '0;
        end else if (i_cmd.u_wr) begin
            w_cur_wdata = w_upd_sat;
        end else begin
            w_cur_wdata = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cur_we) begin
            cur_mem[w_vaddr] <= w_cur_wdata;
        end
        if (w_cur_re) begin
            r_cur_rd <= cur_mem[w_cur_raddr];
        end
    end

    // next rank accumulator memory
    assign w_nxt_re    = i_cmd.e_rd2 | i_cmd.u_rd;
    assign w_nxt_raddr = i_cmd.e_rd2 ? r_dst_rd : w_vaddr;
    assign w_nxt_we    = i_cmd.push_wr | i_cmd.u_wr | i_cmd.clr_wr;
    assign w_nxt_waddr = i_cmd.push_wr ? r_dst_rd : w_vaddr;
    assign w_push_sum  = {1'b0, r_nxt_rd} + {1'b0, w_quo[RANK_W-1:0]};
    always_comb begin
        if (i_cmd.push_wr) begin
            w_nxt_wdata = (w_push_sum > RANK_ONE) ? RANK_ONE[RANK_W-1:0]
                                                  : w_push_sum[RANK_W-1:0];
        end else begin
            w_nxt_wdata = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_nxt_we) begin
            nxt_mem[w_nxt_waddr] <= w_nxt_wdata;
        end
        if (w_nxt_re) begin
            r_nxt_rd <= nxt_mem[w_nxt_raddr];
        end
    end

    // edge store
    always_ff @(posedge i_clk) begin
        if (i_cmd.edge_wr) begin
            src_mem[r_total[EADDR_W-1:0]] <= r_item.edge_source;
            dst_mem[r_total[EADDR_W-1:0]] <= r_item.edge_target;
        end
        if (i_cmd.e_rd) begin
            r_src_rd <= src_mem[i_cmd.edge_idx[EADDR_W-1:0]];
            r_dst_rd <= dst_mem[i_cmd.edge_idx[EADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else if (i_cmd.edge_wr) begin
            r_total <= r_total + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_item <= i_item;
        end
    end

    // divider operand select
    assign w_damp_c = 17'h10000 - {1'b0, i_damping};
    always_comb begin
        case (i_cmd.div_sel)
            DIV_INIT: begin
                w_dividend = DIV_N_W'(RANK_ONE) + DIV_N_W'(i_n >> 1);
                w_divisor  = DIV_D_W'(i_n);
            end
            DIV_TELE: begin
                w_dividend = (DIV_N_W'(w_damp_c) << RANK_FRAC) + (DIV_N_W'(i_n) << 15);
                w_divisor  = DIV_D_W'(i_n) << 16;
            end
            default: begin
                w_dividend = DIV_N_W'(r_cur_rd);
                w_divisor  = DIV_D_W'(r_deg_rd);
            end
        endcase
    end

    prpi_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_div_sel <= i_cmd.div_sel;
        end
        if (w_div_done && r_div_sel == DIV_INIT) begin
            r_init <= w_quo[RANK_W-1:0];
        end
        if (w_div_done && r_div_sel == DIV_TELE) begin
            r_tele <= w_quo[RANK_W-1:0];
        end
    end

    // damping and teleport term
    always_ff @(posedge i_clk) begin
        if (i_cmd.u_mul) begin
            r_prod <= 48'(i_damping) * 48'(r_nxt_rd);
        end
    end

    assign w_rnd     = 49'(r_prod) + 49'(32768);
    assign w_damped  = w_rnd[48:16];
    assign w_upd     = 34'(w_damped) + 34'(r_tele);
    assign w_upd_sat = (w_upd > 34'(RANK_ONE)) ? RANK_ONE[RANK_W-1:0] : w_upd[RANK_W-1:0];

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_init) begin
            r_res_rank   <= '0;
            r_res_status <= i_cmd.res_status;
        end else if (i_cmd.res_rank_cap) begin
            r_res_rank <= r_cur_rd;
        end
    end

    assign o_sts.func       = r_item.func;
    assign o_sts.edge_bad   = ({1'b0, r_item.edge_source} >= i_n) ||
                              ({1'b0, r_item.edge_target} >= i_n);
    assign o_sts.store_full = (r_total >= EDGE_W'(MAX_EDGES));
    assign o_sts.q_bad      = ({1'b0, r_item.query_vertex} >= i_n);
    assign o_sts.edge_skip  = ({1'b0, r_src_rd} >= i_n) || ({1'b0, r_dst_rd} >= i_n) ||
                              (r_deg_rd == '0);
    assign o_sts.div_done   = w_div_done;
    assign o_sts.edge_total = r_total;

    assign o_res_rank   = r_res_rank;
    assign o_res_status = r_res_status;

endmodule

// ===== rtl/prpi_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: sequences loads, queries, the clearing sweep and the rank rounds.
// Depends on prpi_pkg; drives prpi_dp through t_cmd.
module prpi_ctrl
    import prpi_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_out_free,
    input  logic [NCNT_W-1:0]  i_n,
    input  logic [ROUND_W-1:0] i_rounds,
    input  t_sts               i_sts,
    output t_cmd               o_cmd,
    output logic               o_idle,
    output logic               o_out_push
);

    localparam logic [4:0] S_CLR      = 5'd0;
    localparam logic [4:0] S_IDLE     = 5'd1;
    localparam logic [4:0] S_DEC      = 5'd2;
    localparam logic [4:0] S_LD_WR    = 5'd3;
    localparam logic [4:0] S_Q_CAP    = 5'd4;
    localparam logic [4:0] S_DIV_INIT = 5'd5;
    localparam logic [4:0] S_DIV_TELE = 5'd6;
    localparam logic [4:0] S_INIT_SWP = 5'd7;
    localparam logic [4:0] S_ROUND    = 5'd8;
    localparam logic [4:0] S_E_RD     = 5'd9;
    localparam logic [4:0] S_E_RD2    = 5'd10;
    localparam logic [4:0] S_E_CHK    = 5'd11;
    localparam logic [4:0] S_E_DIV    = 5'd12;
    localparam logic [4:0] S_E_NEXT   = 5'd13;
    localparam logic [4:0] S_U_RD     = 5'd14;
    localparam logic [4:0] S_U_MUL    = 5'd15;
    localparam logic [4:0] S_U_WR     = 5'd16;
    localparam logic [4:0] S_RESP     = 5'd17;

    localparam logic [NCNT_W-1:0] VTX_LAST = NCNT_W'(MAX_VERTICES - 1);

    logic [4:0]         r_state;
    logic [4:0]         n_state;
    logic [NCNT_W-1:0]  r_vtx;
    logic [NCNT_W-1:0]  n_vtx;
    logic [EDGE_W-1:0]  r_edge;
    logic [EDGE_W-1:0]  n_edge;
    logic [ROUND_W-1:0] r_round;
    logic [ROUND_W-1:0] n_round;
    t_cmd               w_cmd;
    logic               w_push;

    always_comb begin
        n_state = r_state;
        n_vtx   = r_vtx;
        n_edge  = r_edge;
        n_round = r_round;
        w_cmd   = '0;
        w_push  = 1'b0;
        case (r_state)
            S_CLR: begin
                w_cmd.clr_wr = 1'b1;
                n_vtx = r_vtx + 1'b1;
                if (r_vtx == VTX_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.take = 1'b1;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                w_cmd.res_init   = 1'b1;
                w_cmd.res_status = STAT_OK;
                n_state = S_RESP;
                case (i_sts.func)
                    FUNC_LOAD: begin
                        if (i_sts.edge_bad) begin
                            w_cmd.res_status = STAT_RANGE;
                        end else if (i_sts.store_full) begin
                            w_cmd.res_status = STAT_FULL;
                        end else begin
                            w_cmd.edge_wr = 1'b1;
                            n_state = S_LD_WR;
                        end
                    end
                    FUNC_COMPUTE: begin
                        w_cmd.div_start = 1'b1;
                        w_cmd.div_sel   = DIV_INIT;
                        n_state = S_DIV_INIT;
                    end
                    FUNC_READ: begin
                        if (i_sts.q_bad) begin
                            w_cmd.res_status = STAT_RANGE;
                        end else begin
                            w_cmd.q_rd = 1'b1;
                            n_state = S_Q_CAP;
                        end
                    end
                    default: begin
                        n_state = S_RESP;
                    end
                endcase
            end
            S_LD_WR: begin
                w_cmd.deg_inc = 1'b1;
                n_state = S_RESP;
            end
            S_Q_CAP: begin
                w_cmd.res_rank_cap = 1'b1;
                n_state = S_RESP;
            end
            S_DIV_INIT: begin
                if (i_sts.div_done) begin
                    w_cmd.div_start = 1'b1;
                    w_cmd.div_sel   = DIV_TELE;
                    n_state = S_DIV_TELE;
                end
            end
            S_DIV_TELE: begin
                if (i_sts.div_done) begin
                    n_vtx   = '0;
                    n_state = S_INIT_SWP;
                end
            end
            S_INIT_SWP: begin
                w_cmd.init_wr = 1'b1;
                n_vtx = r_vtx + 1'b1;
                if (r_vtx == VTX_LAST) begin
                    n_round = '0;
                    n_state = S_ROUND;
                end
            end
            S_ROUND: begin
                n_vtx  = '0;
                n_edge = '0;
                if (r_round == i_rounds) begin
                    n_state = S_RESP;
                end else if (i_sts.edge_total == '0) begin
                    n_state = S_U_RD;
                end else begin
                    n_state = S_E_RD;
                end
            end
            S_E_RD: begin
                w_cmd.e_rd = 1'b1;
                n_state = S_E_RD2;
            end
            S_E_RD2: begin
                w_cmd.e_rd2 = 1'b1;
                n_state = S_E_CHK;
            end
            S_E_CHK: begin
                if (i_sts.edge_skip) begin
                    n_state = S_E_NEXT;
                end else begin
                    w_cmd.div_start = 1'b1;
                    w_cmd.div_sel   = DIV_PUSH;
                    n_state = S_E_DIV;
                end
            end
            S_E_DIV: begin
                if (i_sts.div_done) begin
                    w_cmd.push_wr = 1'b1;
                    n_state = S_E_NEXT;
                end
            end
            S_E_NEXT: begin
                if (r_edge == i_sts.edge_total - 1'b1) begin
                    n_vtx   = '0;
                    n_state = S_U_RD;
                end else begin
                    n_edge  = r_edge + 1'b1;
                    n_state = S_E_RD;
                end
            end
            S_U_RD: begin
                w_cmd.u_rd = 1'b1;
                n_state = S_U_MUL;
            end
            S_U_MUL: begin
                w_cmd.u_mul = 1'b1;
                n_state = S_U_WR;
            end
            S_U_WR: begin
                w_cmd.u_wr = 1'b1;
                if (r_vtx == i_n - 1'b1) begin
                    n_round = r_round + 1'b1;
                    n_state = S_ROUND;
                end else begin
                    n_vtx   = r_vtx + 1'b1;
                    n_state = S_U_RD;
                end
            end
            S_RESP: begin
                // hold the result until the output register frees up
                if (i_out_free) begin
                    w_push  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        w_cmd.vtx      = r_vtx;
        w_cmd.edge_idx = r_edge;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_vtx   <= '0;
            r_edge  <= '0;
            r_round <= '0;
        end else begin
            r_state <= n_state;
            r_vtx   <= n_vtx;
            r_edge  <= n_edge;
            r_round <= n_round;
        end
    end

    assign o_cmd      = w_cmd;
    assign o_idle     = (r_state == S_IDLE);
    assign o_out_push = w_push;

endmodule

// ===== rtl/pagerank_power_iteration_unit.sv =====
`timescale 1ns / 1ps
// Top level: configuration registers, output register, controller and datapath.
// Depends on prpi_pkg, prpi_ctrl, prpi_dp (and prpi_div below it).
//
//  channel  | valid       | stall        | payload
//  ---------+-------------+--------------+-----------------------------
//  input    | i_in_valid  | o_in_stall   | i_in_item  (t_in_item)
//  output   | o_out_valid | i_out_stall  | o_out_item (t_out_item)
//  config   | i_cfg_we    | none         | i_cfg_idx, i_cfg_data
//
// Edge load runs S_DEC, S_LD_WR; rank read S_DEC, S_Q_CAP; other codes S_DEC; all
// then wait in S_RESP for the output. Compute: init and teleport divisions, init
// sweep, rounds of edge pushes and updates; 48-step shared divider sets edge cost.
// After reset a clearing pass over all vertex slots runs with o_in_stall high.
// The output register frees the result path one item ahead of a stalled sink.
module pagerank_power_iteration_unit
    import prpi_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_item,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    logic [NCNT_W-1:0]  r_vertex_count;
    logic [ROUND_W-1:0] r_round_count;
    logic [DAMP_W-1:0]  r_damping;
    logic               r_out_valid;
    t_out_item          r_out;

    logic [NCNT_W-1:0] w_n;
    logic              w_out_free;
    logic              w_idle;
    logic              w_push;
    t_cmd              w_cmd;
    t_sts              w_sts;
    logic [RANK_W-1:0] w_res_rank;
    logic [1:0]        w_res_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= NCNT_W'(1024);
            r_round_count  <= ROUND_W'(20);
            r_damping      <= DAMP_W'(55706);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_VERTEX_COUNT: r_vertex_count <= i_cfg_data[NCNT_W-1:0];
                CFG_ROUND_COUNT:  r_round_count  <= i_cfg_data[ROUND_W-1:0];
                CFG_DAMPING:      r_damping      <= i_cfg_data[DAMP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // clamp n to 1 .. MAX_VERTICES
    always_comb begin
        if (r_vertex_count == '0) begin
            w_n = NCNT_W'(1);
        end else if (r_vertex_count > NCNT_W'(MAX_VERTICES)) begin
            w_n = NCNT_W'(MAX_VERTICES);
        end else begin
            w_n = r_vertex_count;
        end
    end

    assign w_out_free = !r_out_valid || !i_out_stall;

    prpi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_free (w_out_free),
        .i_n        (w_n),
        .i_rounds   (r_round_count),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_idle     (w_idle),
        .o_out_push (w_push)
    );

    prpi_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_item       (i_in_item),
        .i_n          (w_n),
        .i_damping    (r_damping),
        .o_sts        (w_sts),
        .o_res_rank   (w_res_rank),
        .o_res_status (w_res_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_push) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_out.rank_value <= w_res_rank;
            r_out.status     <= w_res_status;
            r_out.edges_held <= w_sts.edge_total;
        end
    end

    assign o_in_stall  = !w_idle;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule
